>>> design/dmgf_pkg.sv
// Shared types and constants for the group-fill cache tag controller.
// No dependencies; used by every module in the design folder.
package dmgf_pkg;

   localparam int LINE_COUNT_DEF = 256;
   localparam int GROUP_SIZE_DEF = 32;
   localparam int TAG_W          = 32;
   localparam int LINE_INDEX_W   = 8;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } mem_cmd_type;

endpackage

>>> design/dmgf_tag_ram.sv
// Tag store: single synchronous memory, one write and one registered read per cycle.
// Depends on dmgf_pkg for the command struct and tag width.
module dmgf_tag_ram #(
   parameter int LINE_COUNT = dmgf_pkg::LINE_COUNT_DEF,
   parameter int IW         = $clog2(LINE_COUNT)
) (
   input  logic                         clock,
   input  dmgf_pkg::mem_cmd_type        cmd,
   input  logic [IW-1:0]                rd_addr,
   input  logic [IW-1:0]                wr_addr,
   input  logic [dmgf_pkg::TAG_W-1:0]   wr_data,
   output logic [dmgf_pkg::TAG_W-1:0]   rd_data
);

   logic [dmgf_pkg::TAG_W-1:0] tag_mem [LINE_COUNT];
   logic [dmgf_pkg::TAG_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         tag_mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= tag_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/dmgf_ctrl.sv
// Sequencer of the tag controller: lookup, write-back read, group fill, clear and reset sweeps,
// miss counter and registered response. Depends on dmgf_pkg; drives dmgf_tag_ram.
module dmgf_ctrl #(
   parameter int LINE_COUNT = dmgf_pkg::LINE_COUNT_DEF,
   parameter int GROUP_SIZE = dmgf_pkg::GROUP_SIZE_DEF,
   parameter int IW         = $clog2(LINE_COUNT)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_kind,
   input  logic [dmgf_pkg::TAG_W-1:0]          req_block_number,
   output logic                                rsp_valid,
   output logic                                rsp_hit,
   output logic [dmgf_pkg::LINE_INDEX_W-1:0]   rsp_line_index,
   output logic [dmgf_pkg::TAG_W-1:0]          rsp_writeback_base,
   output logic [dmgf_pkg::TAG_W-1:0]          rsp_fill_base,
   output logic [dmgf_pkg::TAG_W-1:0]          rsp_miss_total,
   output dmgf_pkg::mem_cmd_type               mem_cmd,
   output logic [IW-1:0]                       mem_rd_addr,
   output logic [IW-1:0]                       mem_wr_addr,
   output logic [dmgf_pkg::TAG_W-1:0]          mem_wr_data,
   input  logic [dmgf_pkg::TAG_W-1:0]          mem_rd_data
);

   localparam int TW      = dmgf_pkg::TAG_W;
   localparam int LW      = dmgf_pkg::LINE_INDEX_W;
   localparam int CNT_MAX = (LINE_COUNT > GROUP_SIZE) ? LINE_COUNT : GROUP_SIZE;
   localparam int CW      = $clog2(CNT_MAX) + 1;

   localparam logic [TW-1:0] LINE_MASK  = TW'(LINE_COUNT - 1);
   localparam logic [TW-1:0] GROUP_MASK = TW'(GROUP_SIZE - 1);
   localparam logic [TW-1:0] GROUP_ADD  = TW'(GROUP_SIZE);
   localparam logic [TW-1:0] SAT_LIMIT  = {TW{1'b1}} - GROUP_ADD;
   localparam logic [CW-1:0] LAST_FILL  = CW'(GROUP_SIZE - 1);
   localparam logic [CW-1:0] LAST_LINE  = CW'(LINE_COUNT - 1);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CMP   = 3'd1;
   localparam logic [2:0] ST_WB    = 3'd2;
   localparam logic [2:0] ST_FILL  = 3'd3;
   localparam logic [2:0] ST_CLEAR = 3'd4;
   localparam logic [2:0] ST_INIT  = 3'd5;

   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [TW-1:0] bn_ff, bn_in;
   logic [TW-1:0] wb_ff, wb_in;
   logic [TW-1:0] miss_ff, miss_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_hit_ff, rsp_hit_in;
   logic [LW-1:0] rsp_line_ff, rsp_line_in;
   logic [TW-1:0] rsp_wb_ff, rsp_wb_in;
   logic [TW-1:0] rsp_fill_ff, rsp_fill_in;
   logic [TW-1:0] rsp_miss_ff, rsp_miss_in;

   logic [TW-1:0] req_line32, line32, lo32, grp32, fill_addr32, miss_sum;

   assign req_line32  = req_block_number & LINE_MASK;
   assign line32      = bn_ff & LINE_MASK;
   assign lo32        = bn_ff & ~GROUP_MASK;
   assign grp32       = lo32 & LINE_MASK;
   // wrap the group through the line mask, as for any other index
   assign fill_addr32 = (grp32 + TW'(cnt_ff)) & LINE_MASK;
   assign miss_sum    = (miss_ff > SAT_LIMIT) ? {TW{1'b1}} : miss_ff + GROUP_ADD;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      bn_in        = bn_ff;
      wb_in        = wb_ff;
      miss_in      = miss_ff;
      rsp_valid_in = 1'b0;
      rsp_hit_in   = rsp_hit_ff;
      rsp_line_in  = rsp_line_ff;
      rsp_wb_in    = rsp_wb_ff;
      rsp_fill_in  = rsp_fill_ff;
      rsp_miss_in  = rsp_miss_ff;
      mem_cmd      = '0;
      mem_rd_addr  = req_line32[IW-1:0];
      mem_wr_addr  = cnt_ff[IW-1:0];
      mem_wr_data  = TW'(cnt_ff);
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               bn_in = req_block_number;
               cnt_in = '0;
               if (req_kind) begin
                  state_in = ST_CLEAR;
               end else begin
                  mem_cmd.rd_en = 1'b1;
                  state_in = ST_CMP;
               end
            end
         end
         ST_CMP: begin
            if (mem_rd_data == bn_ff) begin
               rsp_valid_in = 1'b1;
               rsp_hit_in   = 1'b1;
               rsp_line_in  = line32[LW-1:0];
               rsp_wb_in    = '0;
               rsp_fill_in  = '0;
               rsp_miss_in  = miss_ff;
               state_in     = ST_IDLE;
            end else begin
               // fetch the tag at the group's first line for write-back
               mem_cmd.rd_en = 1'b1;
               mem_rd_addr   = grp32[IW-1:0];
               state_in      = ST_WB;
            end
         end
         ST_WB: begin
            wb_in    = mem_rd_data;
            cnt_in   = '0;
            state_in = ST_FILL;
         end
         ST_FILL: begin
            mem_cmd.wr_en = 1'b1;
            mem_wr_addr   = fill_addr32[IW-1:0];
            mem_wr_data   = lo32 + TW'(cnt_ff);
            if (cnt_ff == LAST_FILL) begin
               miss_in      = miss_sum;
               rsp_valid_in = 1'b1;
               rsp_hit_in   = 1'b0;
               rsp_line_in  = line32[LW-1:0];
               rsp_wb_in    = wb_ff;
               rsp_fill_in  = lo32;
               rsp_miss_in  = miss_sum;
               state_in     = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + CW'(1);
            end
         end
         ST_CLEAR, ST_INIT: begin
            mem_cmd.wr_en = 1'b1;
            if (cnt_ff == LAST_LINE) begin
               state_in = ST_IDLE;
               if (state_ff == ST_CLEAR) begin
                  rsp_valid_in = 1'b1;
                  rsp_hit_in   = 1'b0;
                  rsp_line_in  = '0;
                  rsp_wb_in    = '0;
                  rsp_fill_in  = '0;
                  rsp_miss_in  = miss_ff;
               end
            end else begin
               cnt_in = cnt_ff + CW'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         cnt_ff       <= '0;
         miss_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         miss_ff      <= miss_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bn_ff       <= bn_in;
      wb_ff       <= wb_in;
      rsp_hit_ff  <= rsp_hit_in;
      rsp_line_ff <= rsp_line_in;
      rsp_wb_ff   <= rsp_wb_in;
      rsp_fill_ff <= rsp_fill_in;
      rsp_miss_ff <= rsp_miss_in;
   end

   assign busy               = (state_ff != ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_hit            = rsp_hit_ff;
   assign rsp_line_index     = rsp_line_ff;
   assign rsp_writeback_base = rsp_wb_ff;
   assign rsp_fill_base      = rsp_fill_ff;
   assign rsp_miss_total     = rsp_miss_ff;

   // each request leaves the idle state before its response, so response strobes never abut
   a_no_adjacent_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("response strobes in consecutive cycles");

   a_fill_end_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FILL && cnt_ff == LAST_FILL) |=> (rsp_valid_ff && !rsp_hit_ff))
      else $error("group fill finished without a miss response");

   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !mem_cmd.wr_en)
      else $error("tag write issued while idle");

   a_miss_monotonic: assert property (@(posedge clock) disable iff (reset)
      $past(!reset) |-> (miss_ff >= $past(miss_ff)))
      else $error("miss counter went backwards");

endmodule

>>> design/direct_mapped_group_fill_cache_tags.sv
// Tag controller of a direct-mapped cache with aligned group fills.
// Hit: tag read, then the compare state, then the registered response.
// Miss: compare, write-back read, then GROUP_SIZE tag writes, one per cycle on the memory's write port.
// Clear: a sweep that writes all LINE_COUNT tags, one tag per cycle; the strobe cannot be stalled by the receiver.
// Reset: synchronous; busy stays high during an identity sweep of the tag store.
// Depends on dmgf_pkg, dmgf_tag_ram and dmgf_ctrl.
module direct_mapped_group_fill_cache_tags #(
   parameter int LINE_COUNT = dmgf_pkg::LINE_COUNT_DEF,
   parameter int GROUP_SIZE = dmgf_pkg::GROUP_SIZE_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_kind,
   input  logic [dmgf_pkg::TAG_W-1:0]          req_block_number,
   output logic                                rsp_valid,
   output logic                                rsp_hit,
   output logic [dmgf_pkg::LINE_INDEX_W-1:0]   rsp_line_index,
   output logic [dmgf_pkg::TAG_W-1:0]          rsp_writeback_base,
   output logic [dmgf_pkg::TAG_W-1:0]          rsp_fill_base,
   output logic [dmgf_pkg::TAG_W-1:0]          rsp_miss_total
);

   localparam int IW = $clog2(LINE_COUNT);

   dmgf_pkg::mem_cmd_type          mem_cmd;
   logic [IW-1:0]                  mem_rd_addr;
   logic [IW-1:0]                  mem_wr_addr;
   logic [dmgf_pkg::TAG_W-1:0]     mem_wr_data;
   logic [dmgf_pkg::TAG_W-1:0]     mem_rd_data;

   dmgf_ctrl #(
      .LINE_COUNT (LINE_COUNT),
      .GROUP_SIZE (GROUP_SIZE),
      .IW         (IW)
   ) u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_kind           (req_kind),
      .req_block_number   (req_block_number),
      .rsp_valid          (rsp_valid),
      .rsp_hit            (rsp_hit),
      .rsp_line_index     (rsp_line_index),
      .rsp_writeback_base (rsp_writeback_base),
      .rsp_fill_base      (rsp_fill_base),
      .rsp_miss_total     (rsp_miss_total),
      .mem_cmd            (mem_cmd),
      .mem_rd_addr        (mem_rd_addr),
      .mem_wr_addr        (mem_wr_addr),
      .mem_wr_data        (mem_wr_data),
      .mem_rd_data        (mem_rd_data)
   );

   dmgf_tag_ram #(
      .LINE_COUNT (LINE_COUNT),
      .IW         (IW)
   ) u_tag_ram (
      .clock   (clock),
      .cmd     (mem_cmd),
      .rd_addr (mem_rd_addr),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_data (mem_rd_data)
   );

endmodule
